[design/owf_pkg.sv]
// ----------------------------------------------------------------------------
// owf_pkg
// Shared widths, codes and types of the overwrite-oldest sample FIFO.
// ----------------------------------------------------------------------------
package owf_pkg;

  // Built store depth and longest read burst
  localparam int DEPTH    = 4096;
  localparam int MAX_READ = 64;

  // Field widths
  localparam int SMP_W  = 16;
  localparam int CAP_W  = 13;
  localparam int REQ_W  = 7;
  localparam int OVF_W  = 32;
  localparam int FUNC_W = 2;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_READ + 1);

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_LOAD
  } owf_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_QUERY,
    OP_EMPTY_READ,
    OP_RD_ISSUE,
    OP_RD_LOAD
  } owf_op_t;

  // Controller to datapath
  typedef struct packed {
    owf_op_t op;
    logic    last;
  } owf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CAP_W-1:0] level;
    logic             out_free;
  } owf_status_t;

  // Step a ring index, wrapping at the capacity in use
  function automatic logic [ADDR_W-1:0] ring_advance(input logic [ADDR_W-1:0] idx,
                                                     input logic [CAP_W-1:0]  cap);
    logic [CAP_W-1:0] sum;
    sum = CAP_W'(idx) + CAP_W'(1);
    return (sum >= cap) ? '0 : sum[ADDR_W-1:0];
  endfunction

endpackage

[design/owf_if.sv]
// ----------------------------------------------------------------------------
// owf_if
// Valid/ready channel interfaces: request, response and capacity write.
// ----------------------------------------------------------------------------
interface owf_req_if
  import owf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [SMP_W-1:0]  sample_in;
  logic                     block_end;
  logic [REQ_W-1:0]         request_count;
  logic                     clear_overflow;

  modport source (output valid, func, sample_in, block_end, request_count,
                  clear_overflow, input ready);
  modport sink   (input valid, func, sample_in, block_end, request_count,
                  clear_overflow, output ready);
endinterface

interface owf_rsp_if
  import owf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [SMP_W-1:0]  sample_out;
  logic                     sample_valid;
  logic                     last_result;
  logic [CAP_W-1:0]         fill_count;
  logic [OVF_W-1:0]         overflow_total;
  logic                     write_block_done;

  modport source (output valid, sample_out, sample_valid, last_result, fill_count,
                  overflow_total, write_block_done, input ready);
  modport sink   (input valid, sample_out, sample_valid, last_result, fill_count,
                  overflow_total, write_block_done, output ready);
endinterface

interface owf_cfg_if
  import owf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

[design/overwrite_oldest_sample_fifo_top.sv]
// ----------------------------------------------------------------------------
// overwrite_oldest_sample_fifo_top
// Ring buffer of signed audio samples that overwrites the oldest sample when full.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transaction
//  -------  ---  ---------------------------------------------------------
//  req      in   write one sample, read up to request_count, query drops
//  rsp      out  one result per write/query/empty read, one per sample read
//  cfg      in   capacity write; empties the buffer, keeps the drop count
//
//  Writes, queries and empty reads are taken while the result register
//  is free or being emptied that cycle, and each gives one result.
//  A read of N samples takes the request, then per sample issues the
//  store's registered read and loads it into the result register.
//  A stalled rsp holds the burst in place; no request is taken meanwhile.
//  Reset (rst, synchronous) empties the buffer, zeroes the drop count and
//  sets the capacity to the full depth; the store itself is not cleared.
//
module overwrite_oldest_sample_fifo_top
  import owf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  owf_req_if.sink  req,
  owf_rsp_if.source rsp,
  owf_cfg_if.sink  cfg
);

  owf_cmd_t    cmd;
  owf_status_t status;
  logic        cfg_we;

  // Capacity writes are always taken; the user must send them only while idle (not enforced here)
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  // Sequence acceptance and read bursts
  owf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .func          (req.func),
    .request_count (req.request_count),
    .cfg_pending   (cfg.valid),
    .status        (status),
    .cmd           (cmd)
  );

  // Hold ring state, store samples and drive the result register
  owf_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .sample_in        (req.sample_in),
    .block_end        (req.block_end),
    .clear_overflow   (req.clear_overflow),
    .cfg_we           (cfg_we),
    .cfg_capacity     (cfg.capacity),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .sample_out       (rsp.sample_out),
    .sample_valid     (rsp.sample_valid),
    .last_result      (rsp.last_result),
    .fill_count       (rsp.fill_count),
    .overflow_total   (rsp.overflow_total),
    .write_block_done (rsp.write_block_done)
  );

endmodule

[design/owf_ram.sv]
// ----------------------------------------------------------------------------
// owf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module owf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/owf_ctrl.sv]
// ----------------------------------------------------------------------------
// owf_ctrl
// Request acceptance and read burst sequencing.
// ----------------------------------------------------------------------------
module owf_ctrl
  import owf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [REQ_W-1:0]  request_count,
  input  logic              cfg_pending,
  input  owf_status_t       status,
  output owf_cmd_t          cmd
);

  owf_state_t       state, state_next;
  logic [CNT_W-1:0] remaining, remaining_next;
  logic [CNT_W-1:0] req_sat;
  logic [CNT_W-1:0] burst_len;
  logic             accept;

  // Saturate the request, then limit it to what is held
  always_comb begin
    req_sat   = (request_count > REQ_W'(MAX_READ)) ? CNT_W'(MAX_READ)
                                                   : CNT_W'(request_count);
    burst_len = (status.level < CAP_W'(req_sat)) ? CNT_W'(status.level) : req_sat;
  end

  assign req_ready = (state == ST_IDLE) && status.out_free && !cfg_pending;
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
    end
  end

  always_comb begin
    state_next     = state;
    remaining_next = remaining;
    cmd.op         = OP_NONE;
    cmd.last       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (func == FUNC_WRITE) begin
            cmd.op = OP_WRITE;
          end else if (func == FUNC_QUERY) begin
            cmd.op = OP_QUERY;
          end else if (func == FUNC_READ) begin
            if (burst_len == '0) begin
              cmd.op = OP_EMPTY_READ;
            end else begin
              remaining_next = burst_len;
              state_next     = ST_RD_ISSUE;
            end
          end else begin
            cmd.op = OP_NONE;
          end
        end
      end
      ST_RD_ISSUE: begin
        cmd.op         = OP_RD_ISSUE;
        cmd.last       = (remaining == CNT_W'(1));
        remaining_next = remaining - CNT_W'(1);
        state_next     = ST_RD_LOAD;
      end
      ST_RD_LOAD: begin
        if (status.out_free) begin
          cmd.op     = OP_RD_LOAD;
          state_next = (remaining == '0) ? ST_IDLE : ST_RD_ISSUE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/owf_dp.sv]
// ----------------------------------------------------------------------------
// owf_dp
// Ring indexes, level, drop counter, sample store and result register.
// ----------------------------------------------------------------------------
module owf_dp
  import owf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  owf_cmd_t                cmd,
  output owf_status_t             status,
  input  logic signed [SMP_W-1:0] sample_in,
  input  logic                    block_end,
  input  logic                    clear_overflow,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_capacity,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] sample_out,
  output logic                    sample_valid,
  output logic                    last_result,
  output logic [CAP_W-1:0]        fill_count,
  output logic [OVF_W-1:0]        overflow_total,
  output logic                    write_block_done
);

  logic [CAP_W-1:0]  cap;
  logic [CAP_W-1:0]  cap_next;
  logic [ADDR_W-1:0] write_index;
  logic [ADDR_W-1:0] read_index;
  logic [CAP_W-1:0]  level;
  logic [OVF_W-1:0]  drop_counter;
  logic [CAP_W-1:0]  pend_fill;
  logic              pend_last;
  logic [SMP_W-1:0]  ram_rdata;
  logic              full;
  logic [CAP_W-1:0]  wr_level;
  logic [OVF_W-1:0]  wr_drops;
  logic              load;

  // Clamp the written capacity to the built range
  always_comb begin
    priority if (cfg_capacity == '0) begin
      cap_next = CAP_W'(1);
    end else if (cfg_capacity > CAP_W'(DEPTH)) begin
      cap_next = CAP_W'(DEPTH);
    end else begin
      cap_next = cfg_capacity;
    end
  end

  assign full     = (level >= cap);
  assign wr_level = full ? cap : level + CAP_W'(1);
  assign wr_drops = full ? drop_counter + OVF_W'(1) : drop_counter;

  assign status.level    = level;
  assign status.out_free = !out_valid || out_ready;

  assign load = (cmd.op == OP_WRITE) || (cmd.op == OP_QUERY) ||
                (cmd.op == OP_EMPTY_READ) || (cmd.op == OP_RD_LOAD);

  owf_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.op == OP_WRITE),
    .waddr (write_index),
    .wdata (sample_in),
    .re    (cmd.op == OP_RD_ISSUE),
    .raddr (read_index),
    .rdata (ram_rdata)
  );

  // Ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap          <= CAP_W'(DEPTH);
      write_index  <= '0;
      read_index   <= '0;
      level        <= '0;
      drop_counter <= '0;
    end else if (cfg_we) begin
      cap         <= cap_next;
      write_index <= '0;
      read_index  <= '0;
      level       <= '0;
    end else begin
      unique case (cmd.op)
        OP_WRITE: begin
          if (full) begin
            read_index <= ring_advance(read_index, cap);
          end
          write_index  <= ring_advance(write_index, cap);
          level        <= wr_level;
          drop_counter <= wr_drops;
        end
        OP_QUERY: begin
          if (clear_overflow) begin
            drop_counter <= '0;
          end
        end
        OP_RD_ISSUE: begin
          read_index <= ring_advance(read_index, cap);
          level      <= level - CAP_W'(1);
        end
        OP_NONE, OP_EMPTY_READ, OP_RD_LOAD: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Details of the sample in flight from the store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD_ISSUE) begin
      pend_fill <= level - CAP_W'(1);
      pend_last <= cmd.last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (cmd.op)
        OP_WRITE: begin
          sample_out       <= '0;
          sample_valid     <= 1'b0;
          last_result      <= 1'b1;
          fill_count       <= wr_level;
          overflow_total   <= wr_drops;
          write_block_done <= block_end;
        end
        OP_RD_LOAD: begin
          sample_out       <= ram_rdata;
          sample_valid     <= 1'b1;
          last_result      <= pend_last;
          fill_count       <= pend_fill;
          overflow_total   <= drop_counter;
          write_block_done <= 1'b0;
        end
        default: begin
          // queries and empty reads report the current level and count
          sample_out       <= '0;
          sample_valid     <= 1'b0;
          last_result      <= 1'b1;
          fill_count       <= level;
          overflow_total   <= drop_counter;
          write_block_done <= 1'b0;
        end
      endcase
    end
  end

endmodule
